[rtl/smlps_pkg.sv]
// ----------------------------------------------------------------------------
// smlps_pkg
// Shared constants, request and class codes, and the controller/datapath
// command and status bundles of the segmented sieve unit.
// ----------------------------------------------------------------------------
package smlps_pkg;

	localparam int SEGMENT_DEPTH_DEF = 4096;
	localparam int SCALE_COUNT_DEF   = 40;
	localparam int VALUE_BITS_DEF    = 40;

	localparam int OPERAND_W  = 40;
	localparam int SEG_LEN_W  = 13;
	localparam int LIMIT_W    = 21;
	localparam int CFG_DATA_W = 21;
	localparam int OUT_DATA_W = 72;

	localparam logic [SEG_LEN_W-1:0] SEG_LEN_RST = 13'd4096;
	localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 21'd1048576;

	// register indexes
	localparam logic CFG_SEG_LEN     = 1'b0;
	localparam logic CFG_BLOCK_LIMIT = 1'b1;

	// request types
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_SIEVE = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// entry classes
	localparam logic [1:0] CLASS_NSF     = 2'd0;
	localparam logic [1:0] CLASS_ONE     = 2'd1;
	localparam logic [1:0] CLASS_COUNTED = 2'd2;
	localparam logic [1:0] CLASS_WINDOW  = 2'd3;

	// stored sign codes
	localparam logic [1:0] SIGN_ZERO = 2'b00;
	localparam logic [1:0] SIGN_POS  = 2'b01;

	typedef struct packed {
		logic load;
		logic set_base;
		logic idx_clr;
		logic idx_from_rem;
		logic idx_step;
		logic pp_calc;
		logic div_p;
		logic div_pp;
		logic div_q;
		logic mem_rd_op;
		logic mem_rd_idx;
		logic fill_wr;
		logic walk_wr;
		logic zero_wr;
		logic chunk_clr;
		logic mul_go;
		logic acc_go;
		logic m_calc;
		logic q_lp;
		logic q_div;
		logic sq_go;
		logic lg_go;
		logic res_zero;
		logic res_one;
		logic res_calc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       p_ok;
		logic       off_ok;
		logic       idx_lt_len;
		logic       pp_lt_hi;
		logic       div_busy;
		logic       sq_busy;
		logic       lg_done;
		logic       sign_zero;
		logic       m_is_one;
		logic       prod_ne_m;
		logic       chunk_last;
	} sts_t;

endpackage

[rtl/segmented_mobius_largest_prime_sieve_unit.sv]
// ----------------------------------------------------------------------------
// segmented_mobius_largest_prime_sieve_unit
// Segmented sieve giving the Moebius value and largest prime factor of
// every integer in one segment.
// ----------------------------------------------------------------------------
// The unit handles one item at a time; s_tready is high only while it is
// idle. A start item presets the segment stores, one entry a cycle. A sieve
// item with prime p runs the shared one-bit-a-cycle divider to find the first
// multiple, then walks every multiple in the segment (read, 32-bit chunk
// multiply and accumulate, write back), then divides again and clears the
// sign of every multiple of p*p. A query item does a store read, then starts
// the square root, with the divider beside it when the running product
// differs from the entry value, then the floor-log2 scan. A finished result
// waits in the output register while the unit already takes the next item;
// a query only stalls at its end if that register is still full. Stores are
// undefined after reset and an entry must be preset by a start item before
// it is queried. Configuration writes are taken whenever cfg_we is high and
// belong in idle periods.
// ----------------------------------------------------------------------------
module segmented_mobius_largest_prime_sieve_unit #(
	parameter int SEGMENT_DEPTH = smlps_pkg::SEGMENT_DEPTH_DEF,
	parameter int SCALE_COUNT   = smlps_pkg::SCALE_COUNT_DEF,
	parameter int VALUE_BITS    = smlps_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// [39:0] operand
	input  logic [smlps_pkg::OPERAND_W-1:0]      s_tdata,
	// [1:0] req_type
	input  logic [1:0]                           s_tuser,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [1:0] entry_class, [3:2] mobius_sign, [43:4] largest_prime,
	// [49:44] scale_index, [69:50] square_block, [70] prime_only, [71] zero
	output logic [smlps_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [smlps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	smlps_pkg::cmd_t cmd;
	smlps_pkg::sts_t sts;

	logic [1:0]  entry_class;
	logic [1:0]  mobius_sign;
	logic [39:0] largest_prime;
	logic [5:0]  scale_index;
	logic [19:0] square_block;
	logic        prime_only;

	// sequencer: one item in flight, result handed to the output register
	smlps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, arithmetic units and the result register
	smlps_dp #(
		.SEGMENT_DEPTH (SEGMENT_DEPTH),
		.SCALE_COUNT   (SCALE_COUNT),
		.VALUE_BITS    (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_type       (s_tuser),
		.in_operand    (s_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.entry_class   (entry_class),
		.mobius_sign   (mobius_sign),
		.largest_prime (largest_prime),
		.scale_index   (scale_index),
		.square_block  (square_block),
		.prime_only    (prime_only)
	);

	// pack the result fields, lowest field first
	assign m_tdata = {1'b0, prime_only, square_block, scale_index, largest_prime,
		mobius_sign, entry_class};

endmodule

[rtl/smlps_div.sv]
// ----------------------------------------------------------------------------
// smlps_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module smlps_div #(
	parameter int W = 41
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? W'(trial - {1'b0, dvs_q}) : W'(trial);
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/smlps_sqrt.sv]
// ----------------------------------------------------------------------------
// smlps_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module smlps_sqrt #(
	parameter int W = 41
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W-1:0]         radicand,
	output logic                 busy,
	output logic [(W+1)/2-1:0]   root
);

	localparam int SW = W + (W % 2);
	localparam int RW = SW / 2;
	localparam int CW = $clog2(RW + 1);

	logic [CW-1:0] cnt_q;
	logic [SW-1:0] x_q;
	logic [RW-1:0] root_q;
	logic [RW:0]   rem_q;
	logic [RW+2:0] trial_rem;
	logic [RW+2:0] trial;
	logic          fits;

	assign trial_rem = {rem_q, x_q[SW-1:SW-2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign fits      = trial_rem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(RW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= SW'(radicand);
			root_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			x_q    <= {x_q[SW-3:0], 2'b00};
			root_q <= {root_q[RW-2:0], fits};
			rem_q  <= fits ? (RW+1)'(trial_rem - trial) : (RW+1)'(trial_rem);
		end
	end

	assign busy = cnt_q != '0;
	assign root = root_q;

endmodule

[rtl/smlps_ctrl.sv]
// ----------------------------------------------------------------------------
// smlps_ctrl
// Request sequencer: decodes each item and steps the datapath through the
// preset sweep, the two sieve walks or the query evaluation.
// ----------------------------------------------------------------------------
module smlps_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  smlps_pkg::sts_t sts,
	output smlps_pkg::cmd_t cmd
);

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_DECODE    = 5'd1;
	localparam logic [4:0] ST_FILL      = 5'd2;
	localparam logic [4:0] ST_SQ        = 5'd3;
	localparam logic [4:0] ST_SQCHK     = 5'd4;
	localparam logic [4:0] ST_DIV1      = 5'd5;
	localparam logic [4:0] ST_WALK_RD   = 5'd6;
	localparam logic [4:0] ST_WALK_MUL  = 5'd7;
	localparam logic [4:0] ST_WALK_ACC  = 5'd8;
	localparam logic [4:0] ST_WALK_WR   = 5'd9;
	localparam logic [4:0] ST_DIV2      = 5'd10;
	localparam logic [4:0] ST_ZERO      = 5'd11;
	localparam logic [4:0] ST_QREAD     = 5'd12;
	localparam logic [4:0] ST_QDIV      = 5'd13;
	localparam logic [4:0] ST_ROOT_GO   = 5'd14;
	localparam logic [4:0] ST_ROOT_WAIT = 5'd15;
	localparam logic [4:0] ST_FIN       = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.req_type)
					smlps_pkg::REQ_START: begin
						cmd.set_base = 1'b1;
						cmd.idx_clr  = 1'b1;
						state_d      = ST_FILL;
					end
					smlps_pkg::REQ_SIEVE: begin
						state_d = sts.p_ok ? ST_SQ : ST_IDLE;
					end
					smlps_pkg::REQ_QUERY: begin
						if (sts.off_ok) begin
							cmd.mem_rd_op = 1'b1;
							cmd.m_calc    = 1'b1;
							state_d       = ST_QREAD;
						end else begin
							state_d = ST_IDLE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_FILL: begin
				if (sts.idx_lt_len) begin
					cmd.fill_wr  = 1'b1;
					cmd.idx_step = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SQ: begin
				cmd.pp_calc = 1'b1;
				state_d     = ST_SQCHK;
			end
			ST_SQCHK: begin
				if (sts.pp_lt_hi) begin
					cmd.div_p = 1'b1;
					state_d   = ST_DIV1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV1: begin
				if (!sts.div_busy) begin
					cmd.idx_from_rem = 1'b1;
					state_d          = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				if (sts.idx_lt_len) begin
					cmd.mem_rd_idx = 1'b1;
					cmd.chunk_clr  = 1'b1;
					state_d        = ST_WALK_MUL;
				end else begin
					cmd.div_pp = 1'b1;
					state_d    = ST_DIV2;
				end
			end
			ST_WALK_MUL: begin
				cmd.mul_go = 1'b1;
				state_d    = ST_WALK_ACC;
			end
			ST_WALK_ACC: begin
				cmd.acc_go = 1'b1;
				state_d    = sts.chunk_last ? ST_WALK_WR : ST_WALK_MUL;
			end
			ST_WALK_WR: begin
				cmd.walk_wr  = 1'b1;
				cmd.idx_step = 1'b1;
				state_d      = ST_WALK_RD;
			end
			ST_DIV2: begin
				if (!sts.div_busy) begin
					cmd.idx_from_rem = 1'b1;
					state_d          = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (sts.idx_lt_len) begin
					cmd.zero_wr  = 1'b1;
					cmd.idx_step = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_QREAD: begin
				if (sts.sign_zero) begin
					cmd.res_zero = 1'b1;
					state_d      = ST_FIN;
				end else if (sts.m_is_one) begin
					cmd.res_one = 1'b1;
					state_d     = ST_FIN;
				end else begin
					cmd.res_calc = 1'b1;
					cmd.sq_go    = 1'b1;
					if (sts.prod_ne_m) begin
						cmd.div_q = 1'b1;
						state_d   = ST_QDIV;
					end else begin
						cmd.q_lp = 1'b1;
						state_d  = ST_ROOT_GO;
					end
				end
			end
			ST_QDIV: begin
				if (!sts.div_busy) begin
					cmd.q_div = 1'b1;
					state_d   = ST_ROOT_GO;
				end
			end
			ST_ROOT_GO: begin
				cmd.lg_go = 1'b1;
				state_d   = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (sts.lg_done && !sts.sq_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a waiting item");
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fill_wr, cmd.walk_wr, cmd.zero_wr}))
		else $error("two store writers in one cycle");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready held after an accepted item");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_p || cmd.div_pp || cmd.div_q) |-> !sts.div_busy)
		else $error("divider restarted while busy");
`endif

endmodule

[rtl/smlps_dp.sv]
// ----------------------------------------------------------------------------
// smlps_dp
// Datapath: segment stores, sieve walk arithmetic, query evaluation and the
// result register.
// ----------------------------------------------------------------------------
module smlps_dp #(
	parameter int SEGMENT_DEPTH = smlps_pkg::SEGMENT_DEPTH_DEF,
	parameter int SCALE_COUNT   = smlps_pkg::SCALE_COUNT_DEF,
	parameter int VALUE_BITS    = smlps_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smlps_pkg::cmd_t                     cmd,
	output smlps_pkg::sts_t                     sts,
	input  logic [1:0]                          in_type,
	input  logic [smlps_pkg::OPERAND_W-1:0]     in_operand,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [smlps_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [1:0]                          entry_class,
	output logic [1:0]                          mobius_sign,
	output logic [39:0]                         largest_prime,
	output logic [5:0]                          scale_index,
	output logic [19:0]                         square_block,
	output logic                                prime_only
);

	localparam int VW  = VALUE_BITS;
	localparam int DW  = VW + 1;
	localparam int AW  = $clog2(SEGMENT_DEPTH);
	localparam int LW  = (AW + 1 > smlps_pkg::SEG_LEN_W) ? AW + 1 : smlps_pkg::SEG_LEN_W;
	localparam int IW  = (DW + 1 > LW + 1) ? DW + 1 : LW + 1;
	localparam int KW  = $clog2(DW + 1);
	localparam int RW  = (DW + 1) / 2;
	localparam int NCH = (VW + 31) / 32;

	logic [smlps_pkg::OPERAND_W-1:0] op_q;
	logic [1:0]                      typ_q;
	logic [smlps_pkg::SEG_LEN_W-1:0] seg_len_q;
	logic [smlps_pkg::LIMIT_W-1:0]   limit_q;
	logic [VW-1:0]                   base_q;
	logic [LW-1:0]                   eff_len;
	logic [VW-1:0]                   p;
	logic [31:0]                     p32;
	logic [AW-1:0]                   off_addr;
	logic [DW-1:0]                   hi;

	logic [31:0] chunk;
	logic [31:0] mul_a;
	logic [63:0] mul_out;
	logic [63:0] pp_q;
	logic [63:0] pprod_q;
	logic [VW-1:0] acc_q;
	logic        chunk_q;

	logic [DW-1:0] step_q;
	logic [IW-1:0] idx_q;
	logic [AW-1:0] idx_addr;

	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	logic          div_busy;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	logic [1:0]    sign_mem [SEGMENT_DEPTH];
	logic [VW-1:0] prod_mem [SEGMENT_DEPTH];
	logic [VW-1:0] lp_mem   [SEGMENT_DEPTH];
	logic [1:0]    rd_sign_q;
	logic [VW-1:0] rd_prod_q;
	logic [VW-1:0] rd_lp_q;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic          sign_we;
	logic          prod_we;
	logic [1:0]    sign_wd;
	logic [VW-1:0] prod_wd;
	logic [VW-1:0] lp_wd;

	logic [DW-1:0] m_q;
	logic [DW-1:0] q_q;
	logic [DW-1:0] r_val;
	logic          neg_q;
	logic [1:0]    kind_q;
	logic [DW-1:0] scan_q;
	logic [KW-1:0] k_q;
	logic          lg_done;
	logic          sq_busy;
	logic [RW-1:0] root;
	logic [1:0]    calc_sign;
	logic [6:0]    scale_clamped;
	logic          po_calc;

	// configuration and request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_len_q <= smlps_pkg::SEG_LEN_RST;
			limit_q   <= smlps_pkg::LIMIT_RST;
			base_q    <= VW'(1);
		end else begin
			if (cfg_we && cfg_index == smlps_pkg::CFG_SEG_LEN) begin
				seg_len_q <= cfg_data[smlps_pkg::SEG_LEN_W-1:0];
			end
			if (cfg_we && cfg_index == smlps_pkg::CFG_BLOCK_LIMIT) begin
				limit_q <= cfg_data;
			end
			if (cmd.set_base) begin
				base_q <= VW'(op_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_operand;
			typ_q <= in_type;
		end
	end

	assign eff_len  = (LW'(seg_len_q) > LW'(SEGMENT_DEPTH)) ? LW'(SEGMENT_DEPTH)
		: LW'(seg_len_q);
	assign p        = VW'(op_q);
	assign p32      = 32'(p);
	assign off_addr = op_q[AW-1:0];
	assign hi       = DW'(base_q) + DW'(eff_len);

	// multiplier: prime squared, or one 32-bit chunk of the running product
	assign chunk   = 32'(rd_prod_q >> {chunk_q, 5'b0});
	assign mul_a   = cmd.mul_go ? chunk : p32;
	assign mul_out = 64'(mul_a) * 64'(p32);

	always_ff @(posedge clk) begin
		if (cmd.pp_calc) begin
			pp_q <= mul_out;
		end
		if (cmd.mul_go) begin
			pprod_q <= mul_out;
		end
		if (cmd.chunk_clr) begin
			acc_q   <= '0;
			chunk_q <= 1'b0;
		end else if (cmd.acc_go) begin
			acc_q   <= acc_q + VW'(pprod_q << {chunk_q, 5'b0});
			chunk_q <= ~chunk_q;
		end
	end

	// shared divider: segment base mod step, or entry over running product
	assign div_start    = cmd.div_p || cmd.div_pp || cmd.div_q;
	assign div_dividend = cmd.div_q ? m_q : DW'(base_q);
	assign div_divisor  = cmd.div_q ? DW'(rd_prod_q)
		: (cmd.div_pp ? DW'(pp_q) : DW'(p));

	smlps_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// walk index
	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q  <= '0;
			step_q <= DW'(1);
		end else begin
			if (cmd.div_p) begin
				step_q <= DW'(p);
			end else if (cmd.div_pp) begin
				step_q <= DW'(pp_q);
			end
			if (cmd.idx_from_rem) begin
				idx_q <= (div_rem == '0) ? '0 : IW'(step_q - div_rem);
			end else if (cmd.idx_step) begin
				idx_q <= idx_q + IW'(step_q);
			end
		end
	end

	assign idx_addr = idx_q[AW-1:0];

	// segment stores
	assign rd_addr = cmd.mem_rd_op ? off_addr : idx_addr;
	assign rd_en   = cmd.mem_rd_op || cmd.mem_rd_idx;
	assign sign_we = cmd.fill_wr || cmd.walk_wr || cmd.zero_wr;
	assign prod_we = cmd.fill_wr || cmd.walk_wr;
	assign sign_wd = cmd.fill_wr ? smlps_pkg::SIGN_POS
		: (cmd.walk_wr ? 2'(2'b00 - rd_sign_q) : smlps_pkg::SIGN_ZERO);
	assign prod_wd = cmd.fill_wr ? VW'(1) : acc_q;
	assign lp_wd   = cmd.fill_wr ? VW'(1) : p;

	always_ff @(posedge clk) begin
		if (sign_we) begin
			sign_mem[idx_addr] <= sign_wd;
		end
		if (rd_en) begin
			rd_sign_q <= sign_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (prod_we) begin
			prod_mem[idx_addr] <= prod_wd;
		end
		if (rd_en) begin
			rd_prod_q <= prod_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (prod_we) begin
			lp_mem[idx_addr] <= lp_wd;
		end
		if (rd_en) begin
			rd_lp_q <= lp_mem[rd_addr];
		end
	end

	// query evaluation
	assign r_val = (rd_prod_q == '0) ? '0 : div_quo;

	always_ff @(posedge clk) begin
		if (cmd.m_calc) begin
			m_q <= DW'(base_q) + DW'(off_addr);
		end
		if (cmd.q_lp) begin
			q_q   <= DW'(rd_lp_q);
			neg_q <= 1'b0;
		end else if (cmd.q_div) begin
			q_q   <= (r_val > DW'(rd_lp_q)) ? r_val : DW'(rd_lp_q);
			neg_q <= 1'b1;
		end
		if (cmd.res_zero) begin
			kind_q <= smlps_pkg::CLASS_NSF;
		end else if (cmd.res_one) begin
			kind_q <= smlps_pkg::CLASS_ONE;
		end else if (cmd.res_calc) begin
			kind_q <= smlps_pkg::CLASS_COUNTED;
		end
		if (cmd.lg_go) begin
			scan_q <= q_q;
			k_q    <= '0;
		end else if (!lg_done) begin
			scan_q <= scan_q >> 1;
			k_q    <= k_q + 1'b1;
		end
	end

	assign lg_done = scan_q[DW-1:1] == '0;

	smlps_sqrt #(.W(DW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_go),
		.radicand (m_q),
		.busy     (sq_busy),
		.root     (root)
	);

	assign calc_sign     = neg_q ? 2'(2'b00 - rd_sign_q) : rd_sign_q;
	assign scale_clamped = (7'(k_q) >= 7'(SCALE_COUNT - 1)) ? 7'(SCALE_COUNT - 1)
		: 7'(k_q);
	assign po_calc       = (q_q != '0) && (m_q >= q_q)
		&& ((DW+1)'(m_q) < ((DW+1)'(q_q) << 1));

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (kind_q)
				smlps_pkg::CLASS_NSF: begin
					entry_class   <= smlps_pkg::CLASS_NSF;
					mobius_sign   <= smlps_pkg::SIGN_ZERO;
					largest_prime <= '0;
					scale_index   <= '0;
					square_block  <= '0;
					prime_only    <= 1'b0;
				end
				smlps_pkg::CLASS_ONE: begin
					entry_class   <= smlps_pkg::CLASS_ONE;
					mobius_sign   <= smlps_pkg::SIGN_POS;
					largest_prime <= '0;
					scale_index   <= '0;
					square_block  <= 20'd1;
					prime_only    <= 1'b0;
				end
				default: begin
					entry_class   <= (64'(root) >= 64'(limit_q)) ? smlps_pkg::CLASS_WINDOW
						: smlps_pkg::CLASS_COUNTED;
					mobius_sign   <= calc_sign;
					largest_prime <= 40'(q_q);
					scale_index   <= 6'(scale_clamped);
					square_block  <= 20'(root);
					prime_only    <= po_calc;
				end
			endcase
		end
	end

	// status to the controller
	always_comb begin
		sts            = '0;
		sts.req_type   = typ_q;
		sts.p_ok       = (p >= VW'(2)) && ((p >> 32) == '0);
		sts.off_ok     = 64'(op_q) < 64'(eff_len);
		sts.idx_lt_len = idx_q < IW'(eff_len);
		sts.pp_lt_hi   = 66'(pp_q) < 66'(hi);
		sts.div_busy   = div_busy;
		sts.sq_busy    = sq_busy;
		sts.lg_done    = lg_done;
		sts.sign_zero  = rd_sign_q == smlps_pkg::SIGN_ZERO;
		sts.m_is_one   = m_q == DW'(1);
		sts.prod_ne_m  = DW'(rd_prod_q) != m_q;
		sts.chunk_last = chunk_q == 1'(NCH - 1);
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the segmented sieve unit. A directed table covers
// the extremes and the special cases. Random segments follow: preset, sieve
// with primes in rising order, then queries on entries that were preset.
// Every query result is checked field by field, against typed-in expectations
// or a behavioural predictor of the entry stores.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// request code that the unit must drop
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// how a directed row is checked
	localparam logic [1:0] ROW_PRED = 2'd0;
	localparam logic [1:0] ROW_WANT = 2'd1;
	localparam logic [1:0] ROW_NONE = 2'd2;

	localparam int STORE_DEPTH = 4096;
	localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;
	localparam logic [39:0] ALL_ONES = 40'hFF_FFFF_FFFF;
	localparam int RAND_ITEMS = 825;
	localparam int STALL_LIMIT = 200000;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic [1:0]  cls;
		logic [1:0]  sgn;
		logic [39:0] lp;
		logic [5:0]  scale;
		logic [19:0] sq;
		logic        prime;
	} verdict_t;

	typedef struct packed {
		logic [1:0]  req;
		logic [39:0] opnd;
		logic [1:0]  chk;
		verdict_t    want;
	} row_t;

	localparam verdict_t V_ZERO = '0;

	logic clk;
	logic arst_n;
	logic [smlps_pkg::OPERAND_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic s_tvalid;
	logic s_tready;
	logic [smlps_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready;
	logic cfg_we;
	logic cfg_index;
	logic [smlps_pkg::CFG_DATA_W-1:0] cfg_data;

	segmented_mobius_largest_prime_sieve_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the unit's state
	byte             sign_mem[STORE_DEPTH];
	longint unsigned prod_mem[STORE_DEPTH];
	longint unsigned lastp_mem[STORE_DEPTH];
	longint unsigned seg_base;
	int unsigned     seg_len;
	int unsigned     win_limit;
	int unsigned     preset_n;    // entries below this were preset by a start

	verdict_t        pending_q[$];
	int              errs;
	int              fed;
	bit              hold_req;
	bit              calm;        // stretches with no idling on either side
	int unsigned     primes[$];

	always #2 clk = ~clk;

	function automatic int unsigned seg_span();
		return (seg_len > STORE_DEPTH) ? STORE_DEPTH : seg_len;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void preset_segment(longint unsigned b);
		seg_base = b & MASK40;
		for (int i = 0; i < seg_span(); i++) begin
			sign_mem[i] = 1;
			prod_mem[i] = 1;
			lastp_mem[i] = 1;
		end
		if (seg_span() > preset_n)
			preset_n = seg_span();
	endfunction

	function automatic void sieve_prime(longint unsigned p);
		longint unsigned hi, pp, x;
		hi = seg_base + seg_span();
		if (p < 2 || p >= (64'd1 << 32))
			return;
		pp = p * p;
		if (pp >= hi)
			return;
		// flip and multiply every multiple, then clear multiples of the square
		for (x = ((seg_base + p - 1) / p) * p; x < hi; x += p) begin
			sign_mem[x - seg_base] = -sign_mem[x - seg_base];
			prod_mem[x - seg_base] = (prod_mem[x - seg_base] * p) & MASK40;
			lastp_mem[x - seg_base] = p;
		end
		for (x = ((seg_base + pp - 1) / pp) * pp; x < hi; x += pp)
			sign_mem[x - seg_base] = 0;
	endfunction

	function automatic bit classify_entry(longint unsigned off, output verdict_t v);
		longint unsigned m, q, r, c, n;
		int s, k;
		v = V_ZERO;
		if (off >= seg_span())
			return 0;
		s = sign_mem[off];
		m = seg_base + off;
		if (s == 0)
			return 1;
		if (m == 1) begin
			v.cls = smlps_pkg::CLASS_ONE;
			v.sgn = 2'b01;
			v.sq = 20'd1;
			return 1;
		end
		// the unsieved cofactor flips the sign once more
		if (prod_mem[off] != m) begin
			r = prod_mem[off] ? m / prod_mem[off] : 0;
			s = -s;
			q = (r > lastp_mem[off]) ? r : lastp_mem[off];
		end else begin
			q = lastp_mem[off];
		end
		c = q ? m / q : 0;
		k = 0;
		for (longint unsigned t = q; t > 1; t >>= 1)
			k++;
		if (k > 39)
			k = 39;
		n = isqrt(m);
		v.cls = (n >= win_limit) ? smlps_pkg::CLASS_WINDOW : smlps_pkg::CLASS_COUNTED;
		v.sgn = 2'(s);
		v.lp = q[39:0];
		v.scale = 6'(k);
		v.sq = n[19:0];
		v.prime = (c == 1);
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item and hold it until the unit takes it; then update the
	// predictor and queue whatever result the item is due to give.
	task automatic offer_item(logic [1:0] req, logic [39:0] opnd, logic [1:0] chk,
			verdict_t want);
		verdict_t v;
		int g;
		s_tuser <= req;
		s_tdata <= opnd;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		case (req)
			smlps_pkg::REQ_START: preset_segment(opnd);
			smlps_pkg::REQ_SIEVE: sieve_prime(opnd);
			smlps_pkg::REQ_QUERY: begin
				if (chk == ROW_WANT)
					pending_q.push_back(want);
				else if (chk == ROW_PRED && classify_entry(opnd, v))
					pending_q.push_back(v);
			end
			default: ;
		endcase
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send(logic [1:0] req, logic [39:0] opnd);
		offer_item(req, opnd, ROW_PRED, V_ZERO);
	endtask

	// Drop valid, drain every result and wait for the unit to go idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0 || !s_tready);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= smlps_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == smlps_pkg::CFG_SEG_LEN)
			seg_len = val & 32'h1FFF;
		else
			win_limit = val & 32'h1F_FFFF;
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errs++;
		end
	endtask

	// result checker: unpack the fields from the lowest bit up
	always @(posedge clk) begin
		verdict_t e, a;
		if (arst_n && m_tvalid && m_tready) begin
			a.cls = m_tdata[1:0];
			a.sgn = m_tdata[3:2];
			a.lp = m_tdata[43:4];
			a.scale = m_tdata[49:44];
			a.sq = m_tdata[69:50];
			a.prime = m_tdata[70];
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, a);
				errs++;
			end else begin
				e = pending_q.pop_front();
				check_field("entry_class", e.cls, a.cls);
				check_field("mobius_sign", e.sgn, a.sgn);
				check_field("largest_prime", e.lp, a.lp);
				check_field("scale_index", e.scale, a.scale);
				check_field("square_block", e.sq, a.sq);
				check_field("prime_only", e.prime, a.prime);
			end
		end
	end

	// watchdog: end the run after a long spell with no item moving
	always @(posedge clk) begin
		int quiet;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off to back the unit up
	initial begin
		int g;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				g = pick_gap();
				if (g > 0) begin
					m_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// directed rows on a 16 entry segment; expectations typed in where obvious
	row_t plan[24];

	initial begin
		longint unsigned b, hi;
		int unsigned nq, np;
		logic [39:0] off;
		bit held;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = smlps_pkg::REQ_START;
		cfg_we = 1'b0;
		cfg_index = smlps_pkg::CFG_SEG_LEN;
		cfg_data = '0;
		errs = 0;
		fed = 0;
		hold_req = 0;
		held = 0;
		calm = 0;
		seg_base = 1;
		seg_len = 4096;
		win_limit = 1048576;
		preset_n = 0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			sign_mem[i] = 0;
			prod_mem[i] = 0;
			lastp_mem[i] = 0;
		end
		for (int unsigned p = 2; p < 300; p++) begin
			bit isp;
			isp = 1;
			for (int unsigned d = 2; d * d <= p; d++)
				if (p % d == 0)
					isp = 0;
			if (isp)
				primes.push_back(p);
		end

		plan = '{
			'{smlps_pkg::REQ_START,  40'd1,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_QUERY,  40'd0,    ROW_WANT,
				'{smlps_pkg::CLASS_ONE, 2'b01, 40'd0, 6'd0, 20'd1, 1'b0}},
			'{smlps_pkg::REQ_SIEVE,  40'd2,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_SIEVE,  40'd3,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_SIEVE,  40'd5,    ROW_PRED, V_ZERO},   // square past the end
			'{smlps_pkg::REQ_QUERY,  40'd3,    ROW_WANT, V_ZERO},   // four: not squarefree
			'{smlps_pkg::REQ_QUERY,  40'd1,    ROW_WANT,
				'{smlps_pkg::CLASS_COUNTED, 2'b11, 40'd2, 6'd1, 20'd1, 1'b1}},
			'{smlps_pkg::REQ_QUERY,  40'd5,    ROW_WANT,
				'{smlps_pkg::CLASS_COUNTED, 2'b01, 40'd3, 6'd1, 20'd2, 1'b0}},
			'{smlps_pkg::REQ_QUERY,  40'd16,   ROW_NONE, V_ZERO},   // offset past the segment
			'{REQ_UNUSED,            ALL_ONES, ROW_NONE, V_ZERO},
			'{smlps_pkg::REQ_SIEVE,  40'd0,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_SIEVE,  40'd1,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_SIEVE,  ALL_ONES, ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_QUERY,  40'd15,   ROW_WANT, V_ZERO},   // sixteen
			'{smlps_pkg::REQ_QUERY,  ALL_ONES, ROW_NONE, V_ZERO},
			'{smlps_pkg::REQ_QUERY,  40'd7,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_START,  ALL_ONES, ROW_PRED, V_ZERO},   // top of the range
			'{smlps_pkg::REQ_QUERY,  40'd0,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_QUERY,  40'd15,   ROW_PRED, V_ZERO},   // value past 40 bits
			'{smlps_pkg::REQ_START,  40'd0,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_QUERY,  40'd0,    ROW_PRED, V_ZERO},   // entry value zero
			'{smlps_pkg::REQ_SIEVE,  40'd2,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_QUERY,  40'd0,    ROW_PRED, V_ZERO},
			'{smlps_pkg::REQ_QUERY,  40'd9,    ROW_PRED, V_ZERO}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(smlps_pkg::CFG_SEG_LEN, 16);
		write_reg(smlps_pkg::CFG_BLOCK_LIMIT, 1048576);
		foreach (plan[i])
			offer_item(plan[i].req, plan[i].opnd, plan[i].chk, plan[i].want);
		settle();

		// random segments: preset, sieve in rising order, query preset entries
		for (int ph = 0; fed < RAND_ITEMS; ph++) begin
			if (ph % 6 == 0) begin
				settle();
				case (ph / 6)
					0: begin
						write_reg(smlps_pkg::CFG_SEG_LEN, 8191);
						write_reg(smlps_pkg::CFG_BLOCK_LIMIT, 0);
					end
					1: begin
						write_reg(smlps_pkg::CFG_SEG_LEN, 1);
						write_reg(smlps_pkg::CFG_BLOCK_LIMIT, 21'h1F_FFFF);
					end
					2: begin
						write_reg(smlps_pkg::CFG_SEG_LEN, 2);
						write_reg(smlps_pkg::CFG_BLOCK_LIMIT, 1);
					end
					default: begin
						write_reg(smlps_pkg::CFG_SEG_LEN, ($urandom_range(0, 29) == 0) ?
							$urandom_range(301, 4096) : $urandom_range(1, 80));
						write_reg(smlps_pkg::CFG_BLOCK_LIMIT, ($urandom_range(0, 1) == 0) ?
							$urandom_range(0, 200) : $urandom_range(0, 21'h1F_FFFF));
					end
				endcase
			end
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 19))
				0, 1, 2: b = {$urandom_range(0, 255), $urandom};
				3: b = MASK40 - 64'($urandom_range(0, seg_span()));
				4, 5, 6, 7: b = 64'($urandom_range(0, 100000));
				default: b = 64'($urandom_range(0, 3000));
			endcase
			send(smlps_pkg::REQ_START, 40'(b));
			fed++;
			hi = b + seg_span();
			np = (seg_span() > 300) ? 3 : primes.size();
			for (int i = 0; i < np; i++) begin
				send(smlps_pkg::REQ_SIEVE, 40'(primes[i]));
				fed++;
				if (primes[i] * primes[i] >= hi || $urandom_range(0, 29) == 0)
					break;
			end
			nq = $urandom_range(1, 10);
			for (int i = 0; i < nq; i++) begin
				off = 40'($urandom_range(0,
					((seg_span() < preset_n) ? seg_span() : preset_n) - 1));
				send(smlps_pkg::REQ_QUERY, off);
				fed++;
			end
			// noise the unit must drop
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: send(REQ_UNUSED, 40'({$urandom_range(0, 255), $urandom}));
					1: send(smlps_pkg::REQ_SIEVE, 40'({$urandom_range(0, 255), $urandom}));
					2: send(smlps_pkg::REQ_SIEVE, 40'($urandom_range(0, 1)));
					3: send(smlps_pkg::REQ_QUERY, 40'($urandom_range(seg_span(), 8191)));
					default: send(smlps_pkg::REQ_QUERY,
						40'({$urandom_range(0, 255), $urandom}));
				endcase
			end
			// back the unit up once with a burst of queries behind a long hold-off
			if (!held && fed > 400) begin
				held = 1;
				calm = 1;
				hold_req = 1;
				for (int i = 0; i < 12; i++)
					send(smlps_pkg::REQ_QUERY, 40'($urandom_range(0,
						((seg_span() < preset_n) ? seg_span() : preset_n) - 1)));
			end
		end

		settle();
		repeat (200) @(posedge clk);
		if (pending_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_q.size());
			errs++;
		end
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
